// ===== hdl/schroeder_reverb_core_macros.svh =====
// Assertion helpers for the reverb core.
// Both forms sample on clk and are switched off while rst_n is low.
`ifndef SCHROEDER_REVERB_CORE_MACROS_SVH
`define SCHROEDER_REVERB_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/srv_pkg.sv =====
package srv_pkg;

  // Line counts and default line depths.
  localparam int COMB_COUNT             = 4;
  localparam int ALLPASS_COUNT          = 2;
  localparam int LINE_W                 = $clog2(COMB_COUNT);
  localparam int DEF_COMB_LINE_DEPTH    = 2048;
  localparam int DEF_ALLPASS_LINE_DEPTH = 1024;

  // Nominal line lengths.
  localparam int COMB_LEN_RAW [COMB_COUNT]    = '{1116, 1188, 1277, 1356};
  localparam int AP_LEN_RAW   [ALLPASS_COUNT] = '{556, 441};

  // Fixed-point constants.
  localparam logic [15:0] Q15_ONE         = 16'd32768;
  localparam logic [15:0] FB_BASE         = 16'd22938;
  localparam logic [29:0] FB_SPAN         = 30'd9175;
  localparam logic [15:0] ROOM_SIZE_RESET = 16'd16384;
  localparam logic [15:0] WET_MIX_RESET   = 16'd6554;

  // Result queue depth; a power of two.
  localparam int OUT_FIFO_DEPTH = 4;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 1;
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROOM_SIZE = 1'b0,
    REG_WET_MIX   = 1'b1
  } reg_idx_t;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [23:0] acc24_t;

  // Line length limited to one less than the storage depth.
  function automatic int clip_len(input int raw, input int depth);
    return (raw < depth) ? raw : depth - 1;
  endfunction

  // Register values above one count as one.
  function automatic logic [15:0] clamp_q15(input logic [15:0] v);
    return (v > Q15_ONE) ? Q15_ONE : v;
  endfunction

  // Comb feedback gain, 0.7 + 0.28 * room size, rounded.
  function automatic logic [15:0] comb_fb(input logic [15:0] rs);
    logic [29:0] p;
    p = FB_SPAN * {14'd0, clamp_q15(rs)} + 30'd16384;
    return FB_BASE + {1'b0, p[29:15]};
  endfunction

  // Saturation to the 24-bit internal range.
  function automatic acc24_t sat24(input logic signed [25:0] v);
    acc24_t r;
    if (v > 26'sd8388607) begin
      r = 24'sh7fffff;
    end else if (v < -26'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Saturation to the 16-bit output range.
  function automatic sample_t sat16(input logic signed [26:0] v);
    sample_t r;
    if (v > 27'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -27'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/schroeder_reverb_core.sv =====
// Schroeder reverberator: four parallel feedback comb lines, their average
// through two series allpass lines, then a dry/wet mix.
// Input channel in_*: one signed Q1.15 sample per request. Output channel
// out_*: one mixed, saturated Q1.15 sample per input request, in order.
// The configuration port writes room_size (index 0) and wet_mix (index 1);
// write it only while no sample is in flight.
// The comb store has one read port, and each sample reads its four comb lines
// in turn in sequencer states C0 to C3; a new sample can be taken during C3.
// On its way to out_tvalid a sample passes those states, the registered stages
// B to H and then the result queue, in that order.
// Reset clears the positions, valid bits, queue counts and a per-line "filled" flag;
// until a line has wrapped once, its reads return zero, so the stores need
// no clearing pass and the block takes samples from the first cycle on.
// A four-entry result queue sits at the output. New samples are only taken
// while the queue can hold every sample in flight, so a stalled receiver
// holds off the input side and no result is ever dropped.
`include "schroeder_reverb_core_macros.svh"

module schroeder_reverb_core
  import srv_pkg::*;
#(
  parameter int COMB_LINE_DEPTH    = DEF_COMB_LINE_DEPTH,
  parameter int ALLPASS_LINE_DEPTH = DEF_ALLPASS_LINE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,    // [15:0] sample_in
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,   // [15:0] sample_out
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [15:0]           cfg_wr_data
);

  localparam int CPW            = $clog2(COMB_LINE_DEPTH);
  localparam int APW            = $clog2(ALLPASS_LINE_DEPTH);
  localparam int COMB_MEM_DEPTH = COMB_COUNT * COMB_LINE_DEPTH;
  localparam int AP_MEM_DEPTH   = ALLPASS_COUNT * ALLPASS_LINE_DEPTH;
  localparam int CMW            = $clog2(COMB_MEM_DEPTH);
  localparam int AMW            = $clog2(AP_MEM_DEPTH);
  localparam int FPW            = $clog2(OUT_FIFO_DEPTH);
  localparam int OCC_W          = $clog2(OUT_FIFO_DEPTH + 1);

  // Last position of each line before it wraps.
  localparam logic [CPW-1:0] COMB_LAST [COMB_COUNT] = '{
    CPW'(clip_len(COMB_LEN_RAW[0], COMB_LINE_DEPTH) - 1),
    CPW'(clip_len(COMB_LEN_RAW[1], COMB_LINE_DEPTH) - 1),
    CPW'(clip_len(COMB_LEN_RAW[2], COMB_LINE_DEPTH) - 1),
    CPW'(clip_len(COMB_LEN_RAW[3], COMB_LINE_DEPTH) - 1)
  };
  localparam logic [APW-1:0] AP_LAST [ALLPASS_COUNT] = '{
    APW'(clip_len(AP_LEN_RAW[0], ALLPASS_LINE_DEPTH) - 1),
    APW'(clip_len(AP_LEN_RAW[1], ALLPASS_LINE_DEPTH) - 1)
  };

  typedef enum logic [4:0] {
    SEQ_IDLE = 5'b00001,
    SEQ_C0   = 5'b00010,
    SEQ_C1   = 5'b00100,
    SEQ_C2   = 5'b01000,
    SEQ_C3   = 5'b10000
  } seq_state_t;

  // Configuration and derived gains.
  logic [15:0] room_size_r, wet_mix_r;
  logic [15:0] fb_r, w_r, dw_r;

  // Comb read sequencer.
  seq_state_t        seq_state_r, seq_state_nxt;
  sample_t           seq_x_r;
  logic              in_acc;
  logic              issue_vld;
  logic [LINE_W-1:0] issue_line;
  logic [CPW-1:0]    comb_pos_r [COMB_COUNT];
  logic [COMB_COUNT-1:0] comb_full_r;
  logic [CPW-1:0]    pos_cur;
  logic              pos_wrap;
  logic [CMW-1:0]    comb_rd_addr;

  // Comb store and its pipeline.
  acc24_t                comb_mem [COMB_MEM_DEPTH];
  acc24_t                comb_q_r;
  logic                  b_vld_r, b_fresh_r, b_first_r, b_last_r;
  logic [CMW-1:0]        b_addr_r;
  sample_t               b_x_r;
  acc24_t                b_stored;
  logic                  c_vld_r, c_first_r, c_last_r;
  logic signed [40:0]    c_prod_r;
  acc24_t                c_stored_r;
  logic [CMW-1:0]        c_addr_r;
  sample_t               c_x_r;
  logic signed [40:0]    c_rnd;
  logic signed [25:0]    c_round;
  acc24_t                comb_wdata;
  logic signed [25:0]    acc_r, c_tot, y_rnd;

  // Allpass store and its pipeline.
  acc24_t                ap_mem [AP_MEM_DEPTH];
  acc24_t                ap_q_r;
  logic [APW-1:0]        ap_pos_r [ALLPASS_COUNT];
  logic [ALLPASS_COUNT-1:0] ap_full_r;
  logic [AMW-1:0]        ap_addr0, ap_addr1, ap_rd_addr, ap_wr_addr;
  logic                  ap_we;
  acc24_t                ap_wdata;
  logic                  d_vld_r;
  acc24_t                d_y_r;
  sample_t               d_x_r;
  logic                  e_vld_r, e_fresh_r;
  acc24_t                e_y_r, e_stored;
  sample_t               e_x_r;
  logic [AMW-1:0]        e_addr_r;
  logic signed [25:0]    e_half;
  acc24_t                e_wdata;
  logic                  f_vld_r, f_fresh_r;
  acc24_t                f_y_r, f_stored;
  sample_t               f_x_r;
  logic [AMW-1:0]        f_addr_r;
  logic signed [25:0]    f_half;
  acc24_t                f_wdata;

  // Mix stages.
  logic                  g_vld_r;
  acc24_t                g_y_r;
  sample_t               g_x_r;
  logic                  h_vld_r;
  logic signed [32:0]    h_dry_r;
  logic signed [40:0]    h_wet_r;
  logic signed [41:0]    h_mix;
  sample_t               h_out;

  // Result queue.
  sample_t               out_fifo_r [OUT_FIFO_DEPTH];
  logic [FPW-1:0]        fifo_wr_ptr_r, fifo_rd_ptr_r;
  logic [OCC_W-1:0]      fifo_cnt_r, occ_r;
  logic                  fifo_push, out_pop;

  // Configuration writes and the gains derived from them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      room_size_r <= ROOM_SIZE_RESET;
      wet_mix_r   <= WET_MIX_RESET;
      fb_r        <= comb_fb(ROOM_SIZE_RESET);
      w_r         <= clamp_q15(WET_MIX_RESET);
      dw_r        <= Q15_ONE - clamp_q15(WET_MIX_RESET);
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_ROOM_SIZE: room_size_r <= cfg_wr_data;
          REG_WET_MIX:   wet_mix_r   <= cfg_wr_data;
          default:       ;
        endcase
      end
      fb_r <= comb_fb(room_size_r);
      w_r  <= clamp_q15(wet_mix_r);
      dw_r <= Q15_ONE - clamp_q15(wet_mix_r);
    end
  end

  // Accept a sample out of reset when the sequencer is free or finishing,
  // and the result queue has room for everything in flight.
  assign in_tready = rst_n &&
                     ((seq_state_r == SEQ_IDLE) || (seq_state_r == SEQ_C3)) &&
                     (occ_r < OCC_W'(OUT_FIFO_DEPTH));
  assign in_acc    = in_tvalid && in_tready;

  // Sequencer: one comb line read per cycle.
  always_comb begin
    seq_state_nxt = seq_state_r;
    issue_vld     = 1'b1;
    issue_line    = '0;
    unique case (seq_state_r)
      SEQ_IDLE: begin
        issue_vld = 1'b0;
        if (in_acc) begin
          seq_state_nxt = SEQ_C0;
        end
      end
      SEQ_C0: begin
        issue_line    = LINE_W'(0);
        seq_state_nxt = SEQ_C1;
      end
      SEQ_C1: begin
        issue_line    = LINE_W'(1);
        seq_state_nxt = SEQ_C2;
      end
      SEQ_C2: begin
        issue_line    = LINE_W'(2);
        seq_state_nxt = SEQ_C3;
      end
      SEQ_C3: begin
        issue_line    = LINE_W'(3);
        seq_state_nxt = in_acc ? SEQ_C0 : SEQ_IDLE;
      end
      default: begin
        issue_vld     = 1'b0;
        seq_state_nxt = SEQ_IDLE;
      end
    endcase
  end

  assign pos_cur      = comb_pos_r[issue_line];
  assign pos_wrap     = (pos_cur == COMB_LAST[issue_line]);
  assign comb_rd_addr = CMW'(issue_line) * CMW'(COMB_LINE_DEPTH) + CMW'(pos_cur);

  // Sequencer state, positions and filled flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_state_r <= SEQ_IDLE;
      comb_full_r <= '0;
      for (int i = 0; i < COMB_COUNT; i++) begin
        comb_pos_r[i] <= '0;
      end
    end else begin
      seq_state_r <= seq_state_nxt;
      if (issue_vld) begin
        comb_pos_r[issue_line] <= pos_wrap ? '0 : pos_cur + CPW'(1);
        if (pos_wrap) begin
          comb_full_r[issue_line] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      seq_x_r <= in_tdata;
    end
  end

  // Comb store: one read and one write per cycle.
  always_ff @(posedge clk) begin
    if (c_vld_r) begin
      comb_mem[c_addr_r] <= comb_wdata;
    end
    comb_q_r <= comb_mem[comb_rd_addr];
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
    end else begin
      b_vld_r <= issue_vld;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r && c_last_r;
      e_vld_r <= d_vld_r;
      f_vld_r <= e_vld_r;
      g_vld_r <= f_vld_r;
      h_vld_r <= g_vld_r;
    end
  end

  // Read data stage: an entry of a line that never wrapped reads as zero.
  assign b_stored = b_fresh_r ? 24'sd0 : comb_q_r;

  always_ff @(posedge clk) begin
    b_fresh_r  <= !comb_full_r[issue_line];
    b_first_r  <= (seq_state_r == SEQ_C0);
    b_last_r   <= (seq_state_r == SEQ_C3);
    b_addr_r   <= comb_rd_addr;
    b_x_r      <= seq_x_r;
    c_prod_r   <= b_stored * $signed({1'b0, fb_r});
    c_stored_r <= b_stored;
    c_first_r  <= b_first_r;
    c_last_r   <= b_last_r;
    c_addr_r   <= b_addr_r;
    c_x_r      <= b_x_r;
  end

  // Comb write-back value and the running sum of the four outputs.
  assign c_rnd      = c_prod_r + 41'sd16384;
  assign c_round    = $signed(c_rnd[40:15]);
  assign comb_wdata = sat24(c_round + 26'(c_x_r));
  assign c_tot      = (c_first_r ? 26'sd0 : acc_r) + 26'(c_stored_r);
  assign y_rnd      = c_tot + 26'sd2;

  always_ff @(posedge clk) begin
    if (c_vld_r) begin
      acc_r <= c_tot;
    end
    d_y_r <= y_rnd[25:2];
    d_x_r <= c_x_r;
  end

  // Allpass addresses; the first line reads in stage D, the second in E.
  assign ap_addr0   = AMW'(ap_pos_r[0]);
  assign ap_addr1   = AMW'(ALLPASS_LINE_DEPTH) + AMW'(ap_pos_r[1]);
  assign ap_rd_addr = e_vld_r ? ap_addr1 : ap_addr0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap_full_r <= '0;
      for (int i = 0; i < ALLPASS_COUNT; i++) begin
        ap_pos_r[i] <= '0;
      end
    end else begin
      if (d_vld_r) begin
        if (ap_pos_r[0] == AP_LAST[0]) begin
          ap_pos_r[0]  <= '0;
          ap_full_r[0] <= 1'b1;
        end else begin
          ap_pos_r[0] <= ap_pos_r[0] + APW'(1);
        end
      end
      if (e_vld_r) begin
        if (ap_pos_r[1] == AP_LAST[1]) begin
          ap_pos_r[1]  <= '0;
          ap_full_r[1] <= 1'b1;
        end else begin
          ap_pos_r[1] <= ap_pos_r[1] + APW'(1);
        end
      end
    end
  end

  // First allpass line: write y + stored/2, pass stored - y on.
  assign e_stored = e_fresh_r ? 24'sd0 : ap_q_r;
  assign e_half   = (26'(e_stored) + 26'sd1) >>> 1;
  assign e_wdata  = sat24(26'(e_y_r) + e_half);

  // Second allpass line.
  assign f_stored = f_fresh_r ? 24'sd0 : ap_q_r;
  assign f_half   = (26'(f_stored) + 26'sd1) >>> 1;
  assign f_wdata  = sat24(26'(f_y_r) + f_half);

  // Each sample holds the sequencer for all four comb reads, so stages E and F never write together.
  assign ap_we      = e_vld_r || f_vld_r;
  assign ap_wr_addr = e_vld_r ? e_addr_r : f_addr_r;
  assign ap_wdata   = e_vld_r ? e_wdata : f_wdata;

  // Allpass store.
  always_ff @(posedge clk) begin
    if (ap_we) begin
      ap_mem[ap_wr_addr] <= ap_wdata;
    end
    ap_q_r <= ap_mem[ap_rd_addr];
  end

  always_ff @(posedge clk) begin
    e_fresh_r <= !ap_full_r[0];
    e_addr_r  <= ap_addr0;
    e_y_r     <= d_y_r;
    e_x_r     <= d_x_r;
    f_fresh_r <= !ap_full_r[1];
    f_addr_r  <= ap_addr1;
    f_y_r     <= sat24(26'(e_stored) - 26'(e_y_r));
    f_x_r     <= e_x_r;
    g_y_r     <= sat24(26'(f_stored) - 26'(f_y_r));
    g_x_r     <= f_x_r;
    h_dry_r   <= g_x_r * $signed({1'b0, dw_r});
    h_wet_r   <= g_y_r * $signed({1'b0, w_r});
  end

  // Dry/wet sum, rounding and output saturation.
  assign h_mix = 42'(h_wet_r) + 42'(h_dry_r) + 42'sd16384;
  assign h_out = sat16($signed(h_mix[41:15]));

  // Result queue and the count of samples taken but not yet delivered.
  assign fifo_push  = h_vld_r;
  assign out_pop    = out_tvalid && out_tready;
  assign out_tvalid = (fifo_cnt_r != '0);
  assign out_tdata  = out_fifo_r[fifo_rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_wr_ptr_r <= '0;
      fifo_rd_ptr_r <= '0;
      fifo_cnt_r    <= '0;
      occ_r         <= '0;
    end else begin
      if (fifo_push) begin
        fifo_wr_ptr_r <= fifo_wr_ptr_r + FPW'(1);
      end
      if (out_pop) begin
        fifo_rd_ptr_r <= fifo_rd_ptr_r + FPW'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + OCC_W'(fifo_push) - OCC_W'(out_pop);
      occ_r      <= occ_r + OCC_W'(in_acc) - OCC_W'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      out_fifo_r[fifo_wr_ptr_r] <= h_out;
    end
  end

  // Checks on the sequencing and the queue accounting.
  `SRV_ASSERT_NOW(a_fifo_no_overflow, fifo_push,
                  (fifo_cnt_r != OCC_W'(OUT_FIFO_DEPTH)) || out_pop,
                  "result queue written while full")
  `SRV_ASSERT_NOW(a_occ_covers_fifo, 1'b1, occ_r >= fifo_cnt_r,
                  "in-flight count below queue fill")
  `SRV_ASSERT_NOW(a_ap_one_read, 1'b1, !(d_vld_r && e_vld_r),
                  "two allpass reads in one cycle")
  `SRV_ASSERT_NEXT(a_accept_starts_comb, in_acc, seq_state_r == SEQ_C0,
                   "accepted sample did not start the comb reads")

endmodule
